FILE: hw/rtl/sstf_pkg.sv
package sstf_pkg;

  // Default number of tracks in the request bitmap.
  localparam int TRACKS_DEF = 128;

  // Field widths of the transfers.
  localparam int TRACK_W = 7;
  localparam int SEEK_W  = 16;
  localparam int COUNT_W = 8;

  // Operation codes of an input transfer.
  localparam logic OP_MARK = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Input item: one mark or one run request.
  typedef struct packed {
    logic               operation;
    logic [TRACK_W-1:0] track;
  } in_item_t;

  // Result item of one run.
  typedef struct packed {
    logic [SEEK_W-1:0]  total_seek;
    logic [COUNT_W-1:0] served_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mark;
    logic start;
    logic step;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } dp_sts_t;

endpackage

FILE: hw/rtl/sstf_ctrl.sv
module sstf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_operation,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  sstf_pkg::dp_sts_t sts,
  output sstf_pkg::ctl_cmd_t cmd
);
  import sstf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Input transfers are taken only while no run is in progress.
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_RUN) begin
            cmd.start = 1'b1;
            state_nxt = ST_SCAN;
          end else begin
            cmd.mark = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Load the result once the output register is free or drains now.
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The output register stays full until its transfer completes.
  assign out_valid_nxt = (out_valid_r && out_stall) || cmd.load_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/sstf_datapath.sv
module sstf_datapath #(
  parameter int TRACKS = sstf_pkg::TRACKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [sstf_pkg::TRACK_W-1:0] in_track,
  input  sstf_pkg::ctl_cmd_t   cmd,
  output sstf_pkg::dp_sts_t    sts,
  output sstf_pkg::out_item_t  out_data
);
  import sstf_pkg::*;

  localparam int IW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int HW = (IW > TRACK_W) ? IW : TRACK_W;
  localparam int PW = HW + 1;
  localparam logic [PW-1:0] TRACKS_P = PW'(TRACKS);
  localparam logic [PW-1:0] ONE_P    = PW'(1);

  logic [TRACKS-1:0]  map_r, map_nxt;
  logic [HW-1:0]      head_r, head_nxt;
  logic [PW-1:0]      dn_r, dn_nxt;   // next track to inspect below, plus one; zero when exhausted
  logic [PW-1:0]      up_r, up_nxt;   // next track to inspect above
  logic [SEEK_W-1:0]  total_r, total_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  out_item_t          out_data_r;

  logic [PW-1:0]      trk_ext, dn_m1, head_ext, dist_lo, dist_hi, step_dist;
  logic               pend_dn, pend_up, dn_set, up_set, take_lo, take_hi, serve;
  logic [SEEK_W:0]    seek_sum;

  assign trk_ext  = PW'(in_track);
  assign head_ext = {1'b0, head_r};
  assign dn_m1    = dn_r - ONE_P;

  // Pending bits under the two scan pointers.
  assign pend_dn = (dn_r != '0) && (dn_m1 < TRACKS_P) && map_r[dn_m1[IW-1:0]];
  assign pend_up = (up_r < TRACKS_P) && map_r[up_r[IW-1:0]];

  // A pointer is settled when it sits on a request or has run off its end.
  assign dn_set = (dn_r == '0) || pend_dn;
  assign up_set = (up_r >= TRACKS_P) || pend_up;

  // Choose the nearer candidate; a tie goes to the lower track.
  assign dist_lo   = head_ext - dn_m1;
  assign dist_hi   = up_r - head_ext;
  assign take_lo   = dn_set && up_set && pend_dn && (!pend_up || (dist_lo <= dist_hi));
  assign take_hi   = dn_set && up_set && pend_up && !take_lo;
  assign serve     = take_lo || take_hi;
  assign step_dist = take_lo ? dist_lo : dist_hi;

  assign seek_sum = {1'b0, total_r} + (SEEK_W + 1)'(step_dist);

  assign sts.done = dn_set && up_set && !pend_dn && !pend_up;

  // Next values of the scan state.
  always_comb begin
    map_nxt   = map_r;
    head_nxt  = head_r;
    dn_nxt    = dn_r;
    up_nxt    = up_r;
    total_nxt = total_r;
    count_nxt = count_r;
    if (cmd.mark) begin
      if (trk_ext < TRACKS_P) begin
        map_nxt[trk_ext[IW-1:0]] = 1'b1;
      end
    end
    if (cmd.start) begin
      head_nxt  = HW'(in_track);
      dn_nxt    = trk_ext + ONE_P;
      up_nxt    = trk_ext + ONE_P;
      total_nxt = '0;
      count_nxt = '0;
    end
    if (cmd.step) begin
      if (serve) begin
        total_nxt = seek_sum[SEEK_W] ? {SEEK_W{1'b1}} : seek_sum[SEEK_W-1:0];
        if (count_r != {COUNT_W{1'b1}}) begin
          count_nxt = count_r + COUNT_W'(1);
        end
        if (take_lo) begin
          map_nxt[dn_m1[IW-1:0]] = 1'b0;
          head_nxt               = dn_m1[HW-1:0];
          dn_nxt                 = dn_m1;
        end else begin
          map_nxt[up_r[IW-1:0]] = 1'b0;
          head_nxt              = up_r[HW-1:0];
          up_nxt                = up_r + ONE_P;
        end
      end else begin
        if (!dn_set) begin
          dn_nxt = dn_m1;
        end
        if (!up_set) begin
          up_nxt = up_r + ONE_P;
        end
      end
    end
  end

  // The request bitmap is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else begin
      map_r <= map_nxt;
    end
  end

  // Scan pointers, accumulators and the result register.
  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    dn_r    <= dn_nxt;
    up_r    <= up_nxt;
    total_r <= total_nxt;
    count_r <= count_nxt;
    if (cmd.load_out) begin
      out_data_r.total_seek   <= total_r;
      out_data_r.served_count <= count_r;
    end
  end

  assign out_data = out_data_r;

endmodule

FILE: hw/rtl/sstf_disk_scheduler_unit.sv
// Channel | Ports                        | Moves
// --------+------------------------------+-----------------------------------
// input   | in_valid, in_stall, in_data  | mark or run request per transfer
// output  | out_valid, out_stall, out_data | total seek and count per run
//
// A mark transfer produces no result.
// A run scans down and up from the head one track per cycle and serves one request per
// cycle once both sides are settled; the pointers make TRACKS moves in all before the
// result is loaded into the output register.
// Reset (rst_n low, synchronous) clears the request bitmap and the output valid.
// A stalled result stays in the output register; marks are still taken meanwhile.
module sstf_disk_scheduler_unit #(
  parameter int TRACKS = sstf_pkg::TRACKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sstf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sstf_pkg::out_item_t out_data
);
  import sstf_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Sequencer for marks, runs and the result transfer.
  sstf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_data.operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Bitmap, scan pointers and accumulators.
  sstf_datapath #(
    .TRACKS (TRACKS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_track (in_data.track),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

FILE: hw/rtl/sstf_checker.sv
module sstf_checker #(
  parameter int TRACKS = sstf_pkg::TRACKS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sstf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input sstf_pkg::out_item_t out_data
);
  import sstf_pkg::*;

  localparam int COUNT_MAX = (TRACKS < 255) ? TRACKS : 255;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An accepted run blocks further input transfers in the next cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == OP_RUN) |=> in_stall)
    else $error("input taken during a run");

  // A run cannot serve more requests than there are tracks.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.served_count) <= COUNT_MAX))
    else $error("served count beyond track count");

  // A run that serves nothing moves the head nowhere.
  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.served_count != '0) || (out_data.total_seek == '0))
    else $error("seek distance without served requests");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sstf_disk_scheduler_unit sstf_checker #(.TRACKS(TRACKS)) u_sstf_checker (.*);

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sstf_pkg::*;

  // Stimulus sizes and run limits.
  localparam int ITEM_TARGET = 550;
  localparam int CALM_ITEMS  = 60;
  localparam int DRAIN_WAIT  = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Items waiting to be driven and results waiting to be seen.
  in_item_t  item_queue[$];
  out_item_t seek_results[$];

  // Shadow of the request bitmap as the block should hold it.
  bit [TRACKS_DEF-1:0] request_map = '0;

  int item_total = 0;
  int mark_count = 0;
  int run_count = 0;
  int result_count = 0;
  int max_served = 0;
  int err_count = 0;
  int send_gap = 0;
  int stall_left = 0;

  sstf_disk_scheduler_unit #(.TRACKS(TRACKS_DEF)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Serve every pending request nearest-first, lower track on a tie.
  function automatic out_item_t schedule_run(input logic [TRACK_W-1:0] start);
    int head;
    int best;
    int best_dist;
    int span;
    int total;
    int count;
    int t;
    bit found;
    out_item_t res;
    head = start;
    total = 0;
    count = 0;
    best = 0;
    best_dist = 0;
    found = 1'b1;
    while (found) begin
      found = 1'b0;
      for (t = 0; t < TRACKS_DEF; t++) begin
        if (request_map[t]) begin
          span = (t > head) ? (t - head) : (head - t);
          if (!found || span < best_dist) begin
            found = 1'b1;
            best = t;
            best_dist = span;
          end
        end
      end
      if (found) begin
        request_map[best] = 1'b0;
        total += best_dist;
        if (total > 65535) total = 65535;
        if (count < 255) count++;
        head = best;
      end
    end
    res.total_seek = total[SEEK_W-1:0];
    res.served_count = count[COUNT_W-1:0];
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic push_item(input logic op, input int track);
    in_item_t it;
    it.operation = op;
    it.track = track[TRACK_W-1:0];
    item_queue.push_back(it);
    item_total++;
  endtask

  task automatic push_cluster(input int base, input int n);
    int v;
    for (int i = 0; i < n; i++) begin
      v = base + $urandom_range(0, 16) - 8;
      if (v < 0) v = 0;
      if (v > TRACKS_DEF - 1) v = TRACKS_DEF - 1;
      push_item(OP_MARK, v);
    end
  endtask

  // Driver: hold the item until its transfer, with random gaps between items.
  always @(posedge clk) begin
    logic     nxt_valid;
    in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_MARK) begin
          request_map[in_data.track] = 1'b1;
          mark_count++;
        end else begin
          seek_results.push_back(schedule_run(in_data.track));
          run_count++;
        end
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (item_queue.size() > 0) begin
          nxt_data = item_queue.pop_front();
          nxt_valid = 1'b1;
          if (item_queue.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
            send_gap <= $urandom_range(1, 13);
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // Monitor: check each result transfer and stall the output in bursts.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (seek_results.size() == 0) begin
          report("unexpected result", out_data.total_seek, -1);
        end else begin
          want = seek_results.pop_front();
          result_count++;
          if (want.served_count > max_served) max_served = want.served_count;
          if (out_data.total_seek !== want.total_seek)
            report("total_seek", out_data.total_seek, want.total_seek);
          if (out_data.served_count !== want.served_count)
            report("served_count", out_data.served_count, want.served_count);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (item_queue.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int pick;
    int base;
    int mask;
    bit full_done;
    full_done = 1'b0;

    // Empty runs at both ends of the track range.
    push_item(OP_RUN, 0);
    push_item(OP_RUN, TRACKS_DEF - 1);
    // Repeated mark, then a run that starts on the request.
    push_item(OP_MARK, 5);
    push_item(OP_MARK, 5);
    push_item(OP_RUN, 5);
    // Equal distances on both sides: the lower track goes first.
    push_item(OP_MARK, 10);
    push_item(OP_MARK, 20);
    push_item(OP_RUN, 15);
    // Requests at both extremes seen from the middle and from each end.
    push_item(OP_MARK, 0);
    push_item(OP_MARK, TRACKS_DEF - 1);
    push_item(OP_RUN, 64);
    push_item(OP_MARK, TRACKS_DEF - 1);
    push_item(OP_MARK, 0);
    push_item(OP_RUN, 0);
    push_item(OP_MARK, 0);
    push_item(OP_MARK, 126);
    push_item(OP_RUN, TRACKS_DEF - 1);
    push_item(OP_MARK, 64);
    push_item(OP_MARK, 63);
    push_item(OP_MARK, 66);
    push_item(OP_RUN, 64);

    // Random sets of requests, each closed by a run.
    while (item_total < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (!full_done || pick < 2) begin
        // Every track requested, in a scrambled order.
        mask = $urandom_range(0, TRACKS_DEF - 1);
        for (int t = 0; t < TRACKS_DEF; t++) push_item(OP_MARK, t ^ mask);
        push_item(OP_RUN, $urandom_range(0, TRACKS_DEF - 1));
        full_done = 1'b1;
      end else if (pick < 12) begin
        // Runs with nothing pending, or a lone request.
        if ($urandom_range(0, 1)) push_item(OP_MARK, $urandom_range(0, TRACKS_DEF - 1));
        push_item(OP_RUN, $urandom_range(0, TRACKS_DEF - 1));
      end else if (pick < 35) begin
        base = $urandom_range(0, TRACKS_DEF - 1);
        push_cluster(base, $urandom_range(2, 16));
        push_item(OP_RUN, $urandom_range(0, 1) ? base : $urandom_range(0, TRACKS_DEF - 1));
      end else begin
        for (int i = $urandom_range(1, 12); i > 0; i--)
          push_item(OP_MARK, $urandom_range(0, TRACKS_DEF - 1));
        push_item(OP_RUN, $urandom_range(0, TRACKS_DEF - 1));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (item_queue.size() != 0 || in_valid || seek_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (seek_results.size() != 0)
      report("results left over", seek_results.size(), 0);

    $display("Sent %0d marks and %0d runs; checked %0d results.",
             mark_count, run_count, result_count);
    $display("Largest run served %0d requests; %0d mismatches.", max_served, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d items and %0d results outstanding.",
             item_queue.size(), seek_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
